// ===== hw/rtl/cst_pkg.sv =====
// Shared constants for the cursor sequence table: field widths, operation and status codes.
package cst_pkg;

    localparam int KIND_W = 4;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;

    // s_tdata carries value and position, padded to whole bytes
    localparam int IN_BITS = VAL_W + POS_W;
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [STAT_W-1:0] stat_t;
    typedef logic [VAL_W-1:0]  word_t;

    localparam kind_t K_START        = 4'd0;
    localparam kind_t K_END          = 4'd1;
    localparam kind_t K_ADVANCE      = 4'd2;
    localparam kind_t K_RETREAT      = 4'd3;
    localparam kind_t K_INSERT       = 4'd4;
    localparam kind_t K_ATTACH       = 4'd5;
    localparam kind_t K_INSERT_FRONT = 4'd6;
    localparam kind_t K_ATTACH_BACK  = 4'd7;
    localparam kind_t K_REMOVE       = 4'd8;
    localparam kind_t K_REMOVE_FRONT = 4'd9;
    localparam kind_t K_READ         = 4'd10;

    localparam stat_t ST_OK     = 2'd0;
    localparam stat_t ST_FULL   = 2'd1;
    localparam stat_t ST_NONE   = 2'd2;
    localparam stat_t ST_BADIDX = 2'd3;

endpackage

// ===== hw/rtl/cursor_sequence_table.sv =====
// Cursor sequence table: bounded ordered list of signed words with a cursor, one result per word.
//
// Each input word (operation kind on s_tuser, value and position on s_tdata) produces one
// result word holding the entry at the cursor, whether the cursor names an entry, the entry
// count, the entry read by position and a status code. Entries live in a single-port memory
// with a registered read, so one small sequencer walks every shift one entry at a time.
// After acceptance, an insert or attach moves the k entries from its slot up, one read and
// one write each, then writes the value; a remove moves k entries down the same way (k is
// at most DEPTH-1); a good read reads by position; then the cursor entry is read. A new
// word is accepted as soon as the sequencer is back in idle, even while a result still
// waits on m_tready. No clearing pass after reset: only entries that were written are read.
module cursor_sequence_table
    import cst_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // value[31:0], position[36:32], zero pad
    input  logic [KIND_W-1:0] s_tuser,   // kind[3:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [((VAL_W + 1 + $clog2(DEPTH + 1) + VAL_W + STAT_W + 7) / 8) * 8 - 1:0]
                              m_tdata    // current_value, has_current, entry_count,
                                         // read_value, status, zero pad
);

    localparam int AW       = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int OUT_BITS = VAL_W + 1 + CNT_W + VAL_W + STAT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UP_RD  = 4'd1;
    localparam logic [3:0] S_UP_WR  = 4'd2;
    localparam logic [3:0] S_PUT    = 4'd3;
    localparam logic [3:0] S_DN_RD  = 4'd4;
    localparam logic [3:0] S_DN_WR  = 4'd5;
    localparam logic [3:0] S_POS_RD = 4'd6;
    localparam logic [3:0] S_CUR_RD = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_UP   = 2'd1;
    localparam logic [1:0] OP_DN   = 2'd2;

    word_t mem [DEPTH];
    word_t mem_q_reg;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    word_t            val_reg, val_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    stat_t            status_reg, status_next;
    logic             read_ok_reg, read_ok_next;
    word_t            rd_reg, rd_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic             mem_re, mem_we;
    logic [AW-1:0]    mem_raddr, mem_waddr;
    word_t            mem_wdata;

    kind_t            in_kind;
    word_t            in_value;
    logic [POS_W-1:0] in_pos;

    logic             dec_valid, dec_full, dec_read_ok;
    logic [1:0]       dec_op;
    logic [CNT_W-1:0] dec_cursor, dec_used;
    stat_t            dec_status;
    logic             has_cur;

    assign in_kind  = s_tuser;
    assign in_value = s_tdata[VAL_W-1:0];
    assign in_pos   = s_tdata[VAL_W +: POS_W];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign has_cur = (cursor_reg < used_reg);

    always_comb begin
        dec_valid   = (cursor_reg < used_reg);
        dec_full    = (used_reg >= CNT_W'(DEPTH));
        dec_op      = OP_NONE;
        dec_cursor  = cursor_reg;
        dec_used    = used_reg;
        dec_status  = ST_OK;
        dec_read_ok = 1'b0;
        if ((in_kind inside {[K_INSERT:K_ATTACH_BACK]}) && dec_full) begin
            dec_status = ST_FULL;
        end else begin
            case (in_kind)
                K_START: begin
                    dec_cursor = '0;
                end
                K_END: begin
                    dec_cursor = (used_reg != '0) ? used_reg - CNT_W'(1) : '0;
                end
                K_ADVANCE: begin
                    if (dec_valid) begin
                        dec_cursor = cursor_reg + CNT_W'(1);
                    end else begin
                        dec_status = ST_NONE;
                    end
                end
                K_RETREAT: begin
                    if (cursor_reg != '0) begin
                        dec_cursor = cursor_reg - CNT_W'(1);
                    end
                end
                K_INSERT: begin
                    dec_cursor = dec_valid ? cursor_reg : '0;
                    dec_used   = used_reg + CNT_W'(1);
                    dec_op     = OP_UP;
                end
                K_ATTACH: begin
                    dec_cursor = dec_valid ? cursor_reg + CNT_W'(1) : used_reg;
                    dec_used   = used_reg + CNT_W'(1);
                    dec_op     = OP_UP;
                end
                K_INSERT_FRONT: begin
                    dec_cursor = '0;
                    dec_used   = used_reg + CNT_W'(1);
                    dec_op     = OP_UP;
                end
                K_ATTACH_BACK: begin
                    dec_cursor = used_reg;
                    dec_used   = used_reg + CNT_W'(1);
                    dec_op     = OP_UP;
                end
                K_REMOVE: begin
                    if (dec_valid) begin
                        dec_used = used_reg - CNT_W'(1);
                        dec_op   = OP_DN;
                    end else begin
                        dec_status = ST_NONE;
                    end
                end
                K_REMOVE_FRONT: begin
                    if (used_reg != '0) begin
                        dec_cursor = '0;
                        dec_used   = used_reg - CNT_W'(1);
                        dec_op     = OP_DN;
                    end else begin
                        dec_status = ST_NONE;
                    end
                end
                K_READ: begin
                    if (CMP_W'(in_pos) < CMP_W'(used_reg)) begin
                        dec_read_ok = 1'b1;
                    end else begin
                        dec_status = ST_BADIDX;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        used_next     = used_reg;
        cursor_next   = cursor_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        pos_next      = pos_reg;
        status_next   = status_reg;
        read_ok_next  = read_ok_reg;
        rd_next       = rd_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_raddr     = '0;
        mem_waddr     = '0;
        mem_wdata     = mem_q_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    used_next    = dec_used;
                    cursor_next  = dec_cursor;
                    val_next     = in_value;
                    pos_next     = in_pos;
                    status_next  = dec_status;
                    read_ok_next = dec_read_ok;
                    rd_next      = '0;
                    case (dec_op)
                        OP_UP: begin
                            idx_next   = used_reg;
                            state_next = (used_reg == dec_cursor) ? S_PUT : S_UP_RD;
                        end
                        OP_DN: begin
                            idx_next   = dec_cursor;
                            state_next = (dec_cursor < dec_used) ? S_DN_RD : S_CUR_RD;
                        end
                        default: begin
                            state_next = dec_read_ok ? S_POS_RD : S_CUR_RD;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(idx_reg - CNT_W'(1));
                state_next = S_UP_WR;
            end
            S_UP_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(idx_reg);
                mem_wdata  = mem_q_reg;
                idx_next   = idx_reg - CNT_W'(1);
                state_next = ((idx_reg - CNT_W'(1)) == cursor_reg) ? S_PUT : S_UP_RD;
            end
            S_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(cursor_reg);
                mem_wdata  = val_reg;
                state_next = S_CUR_RD;
            end
            S_DN_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(idx_reg + CNT_W'(1));
                state_next = S_DN_WR;
            end
            S_DN_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(idx_reg);
                mem_wdata  = mem_q_reg;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ((idx_reg + CNT_W'(1)) < used_reg) ? S_DN_RD : S_CUR_RD;
            end
            S_POS_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(pos_reg);
                state_next = S_CUR_RD;
            end
            S_CUR_RD: begin
                if (read_ok_reg) begin
                    rd_next = mem_q_reg;
                end
                mem_re     = has_cur;
                mem_raddr  = AW'(cursor_reg);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({status_reg, rd_reg, used_reg, has_cur,
                                            has_cur ? mem_q_reg : word_t'(0)});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            cursor_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            cursor_reg   <= cursor_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
        read_ok_reg <= read_ok_next;
        rd_reg      <= rd_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== bench/tb_cursor_sequence_table.sv =====
// Self-checking stream testbench for the cursor sequence table, with its own sequence predictor.
`timescale 1ns / 1ps

module tb_cursor_sequence_table;
    import cst_pkg::*;

    localparam int DEPTH = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OUT_W = ((VAL_W + 1 + CNT_W + VAL_W + STAT_W + 7) / 8) * 8;
    localparam int HC_BIT = VAL_W;
    localparam int CNT_LO = VAL_W + 1;
    localparam int RD_LO = CNT_LO + CNT_W;
    localparam int ST_LO = RD_LO + VAL_W;
    localparam kind_t K_SPARE_LO = K_READ + kind_t'(1);
    localparam kind_t K_SPARE_HI = '1;
    localparam int RANDOM_OPS = 1800;
    localparam int MAX_WAIT = 18;
    localparam int DRAIN_CYCLES = 80;

    typedef enum int {PH_MIXED, PH_GROW, PH_SHRINK} phase_e;

    typedef struct packed {
        kind_t            kind;
        word_t            value;
        logic [POS_W-1:0] position;
    } op_t;

    typedef struct packed {
        word_t            current_value;
        logic             has_current;
        logic [CNT_W-1:0] entry_count;
        word_t            read_value;
        stat_t            status;
    } view_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;   // value[31:0], position[36:32], zero pad
    logic [KIND_W-1:0] s_tuser = '0;  // kind[3:0]
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;        // current_value, has_current, entry_count,
                                      // read_value, status, zero pad

    op_t   op_q[$];
    view_t view_q[$];
    op_t   cur_op;
    int    src_gap = 0;
    int    snk_hold = 0;
    bit    src_calm = 1'b0;
    bit    snk_calm = 1'b0;
    bit    choke = 1'b0;
    int    accepted = 0;
    int    err_cnt = 0;

    word_t seq_mem[DEPTH];
    int    seq_used = 0;
    int    seq_cursor = 0;

    cursor_sequence_table #(
        .DEPTH(DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    function automatic void open_slot(int at, word_t v);
        for (int i = seq_used; i > at; i--) seq_mem[i] = seq_mem[i - 1];
        seq_mem[at] = v;
        seq_used++;
    endfunction

    function automatic void close_slot(int at);
        for (int i = at; i + 1 < seq_used; i++) seq_mem[i] = seq_mem[i + 1];
        seq_used--;
    endfunction

    function automatic view_t apply_sequence_op(op_t op);
        view_t v;
        stat_t st;
        word_t rd;
        bit    has;
        st = ST_OK;
        rd = '0;
        has = seq_cursor < seq_used;
        if (op.kind >= K_INSERT && op.kind <= K_ATTACH_BACK && seq_used >= DEPTH) begin
            st = ST_FULL;
        end else begin
            case (op.kind)
                K_START: seq_cursor = 0;
                K_END: seq_cursor = (seq_used > 0) ? seq_used - 1 : 0;
                K_ADVANCE: begin
                    if (has) seq_cursor++;
                    else st = ST_NONE;
                end
                K_RETREAT: begin
                    if (seq_cursor > 0) seq_cursor--;
                end
                K_INSERT: begin
                    if (!has) seq_cursor = 0;
                    open_slot(seq_cursor, op.value);
                end
                K_ATTACH: begin
                    seq_cursor = has ? seq_cursor + 1 : seq_used;
                    open_slot(seq_cursor, op.value);
                end
                K_INSERT_FRONT: begin
                    seq_cursor = 0;
                    open_slot(0, op.value);
                end
                K_ATTACH_BACK: begin
                    seq_cursor = seq_used;
                    open_slot(seq_used, op.value);
                end
                K_REMOVE: begin
                    if (has) close_slot(seq_cursor);
                    else st = ST_NONE;
                end
                K_REMOVE_FRONT: begin
                    if (seq_used > 0) begin
                        close_slot(0);
                        seq_cursor = 0;
                    end else begin
                        st = ST_NONE;
                    end
                end
                K_READ: begin
                    if (int'(op.position) < seq_used) rd = seq_mem[op.position];
                    else st = ST_BADIDX;
                end
                default: ;
            endcase
        end
        has = seq_cursor < seq_used;
        v.current_value = has ? seq_mem[seq_cursor] : '0;
        v.has_current = has;
        v.entry_count = CNT_W'(seq_used);
        v.read_value = rd;
        v.status = st;
        return v;
    endfunction

    task automatic add_op(kind_t kind, word_t value, int position);
        op_t op;
        op.kind = kind;
        op.value = value;
        op.position = POS_W'(position);
        op_q.push_back(op);
    endtask

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        op_t nxt;
        int  gap;
        bit  load;
        bit  nv;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            load = 1'b0;
            gap = src_gap;
            nv = s_tvalid;
            if (s_tvalid && s_tready) begin
                view_q.push_back(apply_sequence_op(cur_op));
                accepted <= accepted + 1;
                gap = src_calm ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 31) == 0) src_calm <= !src_calm;
                nv = 1'b0;
                load = (gap == 0);
            end else if (!s_tvalid) begin
                if (gap > 0) gap--;
                else load = 1'b1;
            end
            if (load && op_q.size() > 0) begin
                nxt = op_q.pop_front();
                cur_op <= nxt;
                s_tdata <= {{(IN_W - IN_BITS){1'b0}}, nxt.position, nxt.value};
                s_tuser <= nxt.kind;
                nv = 1'b1;
            end
            s_tvalid <= nv;
            src_gap <= gap;
        end
    end

    always @(posedge aclk) begin
        view_t want;
        view_t got;
        int    hold;
        bit    nr;
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_hold <= 0;
        end else begin
            hold = snk_hold;
            nr = m_tready;
            if (m_tvalid && m_tready) begin
                got.current_value = m_tdata[VAL_W-1:0];
                got.has_current = m_tdata[HC_BIT];
                got.entry_count = m_tdata[CNT_LO +: CNT_W];
                got.read_value = m_tdata[RD_LO +: VAL_W];
                got.status = m_tdata[ST_LO +: STAT_W];
                if (view_q.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    err_cnt++;
                end else begin
                    want = view_q.pop_front();
                    if (got.current_value !== want.current_value) begin
                        $error("current_value: expected %0d, got %0d",
                               $signed(want.current_value), $signed(got.current_value));
                        err_cnt++;
                    end
                    if (got.has_current !== want.has_current) begin
                        $error("has_current: expected %0d, got %0d",
                               want.has_current, got.has_current);
                        err_cnt++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        err_cnt++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.read_value), $signed(got.read_value));
                        err_cnt++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        err_cnt++;
                    end
                end
                hold = snk_calm ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 31) == 0) snk_calm <= !snk_calm;
                nr = (hold == 0);
            end else if (!m_tready) begin
                if (hold > 0) hold--;
                else nr = 1'b1;
            end
            if (choke) nr = 1'b0;
            m_tready <= nr;
            snk_hold <= hold;
        end
    end

    initial begin
        int marks[2];
        marks[0] = 300;
        marks[1] = 1200;
        foreach (marks[i]) begin
            while (accepted < marks[i]) @(posedge aclk);
            choke <= 1'b1;
            repeat (400) @(posedge aclk);
            choke <= 1'b0;
        end
    end

    initial begin
        #10_000_000;
        $display("[cursor_sequence_table] ERROR");
        $finish;
    end

    initial begin
        op_t    op;
        phase_e phase;
        int     phase_left;
        int     r;
        int     guard;

        add_op(K_READ, '0, 0);
        add_op(K_REMOVE, '0, 0);
        add_op(K_REMOVE_FRONT, '0, 0);
        add_op(K_ADVANCE, '0, 0);
        add_op(K_RETREAT, '0, 0);
        add_op(K_END, '0, 0);
        add_op(K_START, '0, 0);
        add_op(K_INSERT, 32'h8000_0000, 0);
        add_op(K_ATTACH, 32'h7FFF_FFFF, 0);
        add_op(K_INSERT_FRONT, 32'h0000_0000, 0);
        add_op(K_ATTACH_BACK, 32'hFFFF_FFFF, 0);
        add_op(K_READ, '0, 3);
        add_op(K_READ, '0, 31);
        add_op(K_START, '0, 0);
        add_op(K_ADVANCE, '0, 0);
        add_op(K_RETREAT, '0, 0);
        add_op(K_END, '0, 0);
        add_op(K_ADVANCE, '0, 0);
        add_op(K_ATTACH, 32'h0000_0001, 0);
        add_op(K_ADVANCE, '0, 0);
        add_op(K_INSERT, 32'h5555_5555, 0);
        add_op(K_REMOVE, '0, 0);
        add_op(K_REMOVE_FRONT, '0, 0);
        add_op(K_SPARE_LO, 32'hAAAA_AAAA, 31);
        add_op(K_SPARE_HI, '0, 0);

        phase = PH_MIXED;
        phase_left = 0;
        repeat (RANDOM_OPS) begin
            if (phase_left == 0) begin
                phase = phase_e'($urandom_range(0, 2));
                phase_left = $urandom_range(40, 120);
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (r < 3)
                op.kind = kind_t'($urandom_range(K_SPARE_LO, K_SPARE_HI));
            else if (phase == PH_GROW && r < 70)
                op.kind = kind_t'($urandom_range(K_INSERT, K_ATTACH_BACK));
            else if (phase == PH_SHRINK && r < 60)
                op.kind = kind_t'($urandom_range(K_REMOVE, K_REMOVE_FRONT));
            else
                op.kind = kind_t'($urandom_range(K_START, K_READ));
            op.value = $urandom();
            op.position = POS_W'($urandom_range(0, 31));
            op_q.push_back(op);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (op_q.size() != 0 || s_tvalid) @(posedge aclk);
        guard = 0;
        while (view_q.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (view_q.size() != 0) begin
            $error("%0d result words never arrived", view_q.size());
        end
        if (err_cnt == 0 && view_q.size() == 0) begin
            $display("[cursor_sequence_table] OK");
        end else begin
            $display("[cursor_sequence_table] ERROR");
        end
        $finish;
    end

endmodule
